// File: src/text_console_writer_core_assert.svh
// Assertion macros shared by the console writer RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tcw_pkg.sv
// Package for the text console writer: default geometry, operation codes,
// control characters and configuration register indexes. No dependencies.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef logic [OP_W-1:0]       t_op;
    typedef logic [CHAR_W-1:0]     t_char;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_op OP_PUT  = 2'd0;
    localparam t_op OP_SET  = 2'd1;
    localparam t_op OP_READ = 2'd2;

    localparam t_char CH_BS    = 8'h08;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_NL    = 8'h0A;
    localparam t_char CH_FF    = 8'h0C;
    localparam t_char CH_CR    = 8'h0D;
    localparam t_char CH_SPACE = 8'h20;

    localparam int TAB_STEP = 8;

    localparam t_cfg_idx CFG_FG    = 2'd0;
    localparam t_cfg_idx CFG_BG    = 2'd1;
    localparam t_cfg_idx CFG_BLINK = 2'd2;

    localparam t_cfg_data FG_RESET = 4'd7;
    localparam t_cfg_data BG_RESET = 4'd0;

endpackage

// File: src/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/text_console_writer_core.sv
// Character-cell text console. A put character (printable or control code) or a
// read cell inside the screen passes through the execute state, then the put or
// read-wait state, then the response state before the next item is accepted; a
// set cursor, the unused op and a read outside the screen skip the middle state.
// A result held up by the output stalls the block in its response state. The
// screen sits in one RAM with a single write port, so a pending wrap that stays on
// the screen adds a pass through the put state, every scroll (pending, or caused
// by a wrap on the bottom row) adds a sweep that clears the new bottom row (rows
// are addressed through a rotating top-row offset, so nothing is copied), and a
// form feed adds a sweep over every cell. After reset a clearing pass zeroes the
// screen before the first item is taken; configuration writes are accepted
// throughout.
`include "text_console_writer_core_assert.svh"

module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    localparam int COL_W  = $clog2(COLUMNS + 1),
    localparam int ROW_W  = $clog2(ROWS + 1),
    localparam int IN_W   = tcw_pkg::OP_W + tcw_pkg::CHAR_W + COL_W + ROW_W,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = COL_W + ROW_W + 2 * tcw_pkg::CHAR_W,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input item, from bit 0 up: op, char_code, col, row, zero padding.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_TW-1:0]     i_s_tdata,
    // Result item, from bit 0 up: cursor_col, cursor_row, cell_char,
    // cell_attr, zero padding.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [OUT_TW-1:0]    o_m_tdata,
    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  tcw_pkg::t_cfg_idx    i_cfg_index,
    input  tcw_pkg::t_cfg_data   i_cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int TOP_W  = $clog2(ROWS);
    localparam int CELL_W = 2 * CHAR_W;

    localparam int IN_CHAR_LO = OP_W;
    localparam int IN_COL_LO  = OP_W + CHAR_W;
    localparam int IN_ROW_LO  = IN_COL_LO + COL_W;

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_RDW   = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_line, n_line;
    logic [TOP_W-1:0]  r_top, n_top;
    logic [ADDR_W-1:0] r_sw_addr, n_sw_addr;
    logic [ADDR_W-1:0] r_sw_last, n_sw_last;
    logic [CELL_W-1:0] r_sw_data, n_sw_data;
    logic [2:0]        r_sw_ret, n_sw_ret;

    t_op               r_in_op, n_in_op;
    t_char             r_in_char, n_in_char;
    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [ROW_W-1:0]  r_in_row, n_in_row;
    t_char             r_res_char, n_res_char;
    t_char             r_res_attr, n_res_attr;

    logic              r_out_valid, n_out_valid;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    t_char             r_out_char, n_out_char;
    t_char             r_out_attr, n_out_attr;

    t_cfg_data         r_fg, r_bg;
    logic              r_blink;

    logic              s_acc;
    logic              do_scroll;
    t_char             print_attr, blank_attr;
    logic [ROW_W:0]    cur_sum, rd_sum;
    logic [ROW_W-1:0]  cur_phys, rd_phys;
    logic [ADDR_W-1:0] cur_addr, rd_addr, top_base;
    logic [COL_W:0]    tab_sum, tab_col;
    logic              rd_in_range;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = OUT_TW'({r_out_attr, r_out_char, r_out_row, r_out_col});

    assign blank_attr = {r_bg[3] | r_blink, r_bg[2:0], 4'h0};
    assign print_attr = {r_bg[3] | r_blink, r_bg[2:0], r_fg};

    // Logical rows map to physical rows through the rotating top-row offset.
    always_comb begin
        cur_sum  = {1'b0, r_line} + (ROW_W + 1)'(r_top);
        cur_phys = (cur_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(cur_sum - (ROW_W + 1)'(ROWS))
                                                   : ROW_W'(cur_sum);
        rd_sum   = {1'b0, r_in_row} + (ROW_W + 1)'(r_top);
        rd_phys  = (rd_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(rd_sum - (ROW_W + 1)'(ROWS))
                                                  : ROW_W'(rd_sum);
        cur_addr = ADDR_W'(cur_phys) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
        rd_addr  = ADDR_W'(rd_phys) * ADDR_W'(COLUMNS) + ADDR_W'(r_in_col);
        top_base = ADDR_W'(r_top) * ADDR_W'(COLUMNS);
        tab_sum  = {1'b0, r_col} + (COL_W + 1)'(TAB_STEP);
        tab_col  = tab_sum & ~(COL_W + 1)'(TAB_STEP - 1);
        rd_in_range = (r_in_col < COL_W'(COLUMNS)) && (r_in_row < ROW_W'(ROWS));
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_line      = r_line;
        n_top       = r_top;
        n_sw_addr   = r_sw_addr;
        n_sw_last   = r_sw_last;
        n_sw_data   = r_sw_data;
        n_sw_ret    = r_sw_ret;
        n_in_op     = r_in_op;
        n_in_char   = r_in_char;
        n_in_col    = r_in_col;
        n_in_row    = r_in_row;
        n_res_char  = r_res_char;
        n_res_attr  = r_res_attr;
        n_out_valid = r_out_valid;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_char  = r_out_char;
        n_out_attr  = r_out_attr;
        ram_we      = 1'b0;
        ram_waddr   = cur_addr;
        ram_wdata   = {print_attr, r_in_char};
        do_scroll   = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_sw_addr;
                ram_wdata = r_sw_data;
                if (r_sw_addr == r_sw_last) begin
                    n_state = r_sw_ret;
                end else begin
                    n_sw_addr = r_sw_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_in_op    = i_s_tdata[OP_W-1:0];
                    n_in_char  = i_s_tdata[IN_CHAR_LO +: CHAR_W];
                    n_in_col   = i_s_tdata[IN_COL_LO +: COL_W];
                    n_in_row   = i_s_tdata[IN_ROW_LO +: ROW_W];
                    n_res_char = '0;
                    n_res_attr = '0;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_in_op)
                    OP_PUT: n_state = S_PUT;
                    OP_SET: begin
                        n_col   = (r_in_col > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                                  : r_in_col;
                        n_line  = (r_in_row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                               : r_in_row;
                        n_state = S_RESP;
                    end
                    // The read address is already on the RAM; data arrives next cycle.
                    OP_READ: n_state = rd_in_range ? S_RDW : S_RESP;
                    default: n_state = S_RESP;
                endcase
            end
            S_PUT: begin
                // Pending scroll first, then pending wrap, then the character itself.
                // Each pass through this state settles one of them.
                if (r_line == ROW_W'(ROWS)) begin
                    do_scroll = 1'b1;
                    n_line    = ROW_W'(ROWS - 1);
                end else if (r_col >= COL_W'(COLUMNS)) begin
                    n_col = '0;
                    if (r_line == ROW_W'(ROWS - 1)) begin
                        do_scroll = 1'b1;
                    end else begin
                        n_line = r_line + 1'b1;
                    end
                end else begin
                    n_state = S_RESP;
                    unique case (r_in_char)
                        CH_NL: begin
                            n_line = r_line + 1'b1;
                            n_col  = '0;
                        end
                        CH_CR: n_col = '0;
                        CH_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                            end
                        end
                        CH_FF: begin
                            n_col     = '0;
                            n_line    = '0;
                            n_sw_addr = '0;
                            n_sw_last = ADDR_W'(CELLS - 1);
                            n_sw_data = {blank_attr, CH_SPACE};
                            n_sw_ret  = S_RESP;
                            n_state   = S_SWEEP;
                        end
                        CH_TAB: begin
                            n_col = (tab_col > (COL_W + 1)'(COLUMNS)) ? COL_W'(COLUMNS)
                                                                      : COL_W'(tab_col);
                        end
                        default: begin
                            ram_we = 1'b1;
                            n_col  = r_col + 1'b1;
                        end
                    endcase
                end
            end
            S_RDW: begin
                n_res_char = ram_rdata[CHAR_W-1:0];
                n_res_attr = ram_rdata[CELL_W-1:CHAR_W];
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_col   = r_col;
                    n_out_row   = r_line;
                    n_out_char  = r_res_char;
                    n_out_attr  = r_res_attr;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A scroll advances the top row; the old top row becomes the blank bottom row.
        if (do_scroll) begin
            n_sw_addr = top_base;
            n_sw_last = top_base + ADDR_W'(COLUMNS - 1);
            n_sw_data = {blank_attr, CH_SPACE};
            n_sw_ret  = S_PUT;
            n_top     = (r_top == TOP_W'(ROWS - 1)) ? '0 : r_top + 1'b1;
            n_state   = S_SWEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_col       <= '0;
            r_line      <= '0;
            r_top       <= '0;
            r_sw_addr   <= '0;
            r_sw_last   <= ADDR_W'(CELLS - 1);
            r_sw_data   <= '0;
            r_sw_ret    <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_line      <= n_line;
            r_top       <= n_top;
            r_sw_addr   <= n_sw_addr;
            r_sw_last   <= n_sw_last;
            r_sw_data   <= n_sw_data;
            r_sw_ret    <= n_sw_ret;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_op    <= n_in_op;
        r_in_char  <= n_in_char;
        r_in_col   <= n_in_col;
        r_in_row   <= n_in_row;
        r_res_char <= n_res_char;
        r_res_attr <= n_res_attr;
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_char <= n_out_char;
        r_out_attr <= n_out_attr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg    <= FG_RESET;
            r_bg    <= BG_RESET;
            r_blink <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FG:    r_fg    <= i_cfg_data;
                CFG_BG:    r_bg    <= i_cfg_data;
                CFG_BLINK: r_blink <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    `TCW_ASSERT_IMPL(a_col_bound, 1'b1, r_col <= COL_W'(COLUMNS), "cursor column out of range")
    `TCW_ASSERT_IMPL(a_line_bound, 1'b1, r_line <= ROW_W'(ROWS), "cursor row out of range")
    `TCW_ASSERT_IMPL(a_top_range, 1'b1, r_top <= TOP_W'(ROWS - 1), "top-row offset out of range")
    `TCW_ASSERT_IMPL(a_we_state, ram_we, r_state == S_SWEEP || r_state == S_PUT, "stray write")
    `TCW_ASSERT_IMPL(a_sweep_bound, r_state == S_SWEEP, r_sw_addr <= r_sw_last, "sweep overran")
    `TCW_ASSERT_NEXT(a_accept_exec, s_acc, r_state == S_EXEC, "accepted item not executed")

endmodule

// File: tb/text_console_writer_core_tb.sv
// Self-checking testbench for text_console_writer_core: drives put, set-cursor, read-cell and
// unused-op items over the input stream, writes the configuration registers, and checks every
// result against a cycle-free console model. Depends on tcw_pkg, tcw_ram and the core.
`timescale 1ns / 1ps

module text_console_writer_core_tb;
    import tcw_pkg::*;

    localparam int COLS       = COLUMNS_DEF;
    localparam int LINES      = ROWS_DEF;
    localparam int CELL_COUNT = COLS * LINES;

    localparam t_op OP_NONE = 2'd3;

    typedef struct packed {
        logic [4:0] row;
        logic [6:0] col;
        t_char      chr;
        t_op        op;
    } item_t;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] chr;
        logic [4:0] cur_row;
        logic [6:0] cur_col;
    } report_t;

    localparam int IN_TW  = (($bits(item_t) + 7) / 8) * 8;
    localparam int OUT_TW = (($bits(report_t) + 7) / 8) * 8;

    localparam int RANDOM_PER_PHASE = 270;
    localparam int ITEM_BUDGET      = 900;
    localparam int FF_CYCLES        = CELL_COUNT + COLS + 16;
    localparam int LIMIT_CYCLES     = CELL_COUNT + ITEM_BUDGET * (FF_CYCLES + 200) * 3;
    localparam int TAIL_CYCLES      = 50;

    // Model of the console: screen store, cursor, colour registers and the
    // queue of cursor/cell reports still owed by the block.
    class console_shadow;
        logic [15:0] cells [CELL_COUNT];
        int unsigned cur_col;
        int unsigned cur_row;
        logic [3:0]  fg;
        logic [3:0]  bg;
        logic        blink;
        report_t     awaited [$];
        int unsigned mismatches;

        function new();
            foreach (cells[i]) cells[i] = 16'h0000;
            cur_col    = 0;
            cur_row    = 0;
            fg         = FG_RESET;
            bg         = BG_RESET;
            blink      = 1'b0;
            mismatches = 0;
        endfunction

        function logic [7:0] blank_attr();
            return {bg, 4'h0} | {blink, 7'h00};
        endfunction

        function void scroll_screen();
            for (int i = COLS; i < CELL_COUNT; i++) cells[i - COLS] = cells[i];
            for (int i = (LINES - 1) * COLS; i < CELL_COUNT; i++)
                cells[i] = {blank_attr(), CH_SPACE};
        endfunction

        function void set_register(t_cfg_idx idx, t_cfg_data val);
            case (idx)
                CFG_FG:    fg    = val;
                CFG_BG:    bg    = val;
                CFG_BLINK: blink = val[0];
                default: ;
            endcase
        endfunction

        function void put_char(t_char ch);
            // Wrap and scroll are both deferred until the next put.
            if (cur_row >= LINES) begin
                scroll_screen();
                cur_row = LINES - 1;
            end
            if (cur_col >= COLS) begin
                cur_col = 0;
                if (cur_row == LINES - 1) scroll_screen();
                else cur_row++;
            end
            case (ch)
                CH_NL: begin
                    cur_row++;
                    cur_col = 0;
                end
                CH_CR: cur_col = 0;
                CH_BS: if (cur_col != 0) cur_col--;
                CH_FF: begin
                    foreach (cells[i]) cells[i] = {blank_attr(), CH_SPACE};
                    cur_col = 0;
                    cur_row = 0;
                end
                CH_TAB: begin
                    cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
                    if (cur_col > COLS) cur_col = COLS;
                end
                default: begin
                    cells[cur_row * COLS + cur_col] = {blank_attr() | {4'h0, fg}, ch};
                    cur_col++;
                end
            endcase
        endfunction

        function void apply_item(item_t it);
            report_t rep;
            rep = '0;
            case (it.op)
                OP_PUT: put_char(it.chr);
                OP_SET: begin
                    cur_col = (it.col > COLS - 1) ? COLS - 1 : it.col;
                    cur_row = (it.row > LINES - 1) ? LINES - 1 : it.row;
                end
                OP_READ: begin
                    if (it.col < COLS && it.row < LINES)
                        {rep.attr, rep.chr} = cells[it.row * COLS + it.col];
                end
                default: ;
            endcase
            rep.cur_col = cur_col[6:0];
            rep.cur_row = cur_row[4:0];
            awaited.push_back(rep);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_result(logic [OUT_TW-1:0] data);
            report_t got;
            report_t want;
            got = data[$bits(report_t)-1:0];
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
            end else begin
                want = awaited.pop_front();
                check_field("cursor_col", 32'(want.cur_col), 32'(got.cur_col));
                check_field("cursor_row", 32'(want.cur_row), 32'(got.cur_row));
                check_field("cell_char", 32'(want.chr), 32'(got.chr));
                check_field("cell_attr", 32'(want.attr), 32'(got.attr));
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [IN_TW-1:0]  i_s_tdata   = '0;
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [OUT_TW-1:0] o_m_tdata;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    t_cfg_idx          i_cfg_index = CFG_FG;
    t_cfg_data         i_cfg_data  = '0;

    console_shadow shadow = new();
    int send_idle_pct = 17;
    int recv_idle_pct = 78;
    int unsigned cycle_count = 0;

    text_console_writer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: outputs are sampled at the edge, tready is redrawn every cycle.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) shadow.compare_result(o_m_tdata);
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic item_t make_item(t_op op, t_char chr, int col, int row);
        item_t it;
        it.op  = op;
        it.chr = chr;
        it.col = col[6:0];
        it.row = row[4:0];
        return it;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    sel;
        it.op  = OP_PUT;
        it.chr = 8'($urandom);
        it.col = 7'($urandom);
        it.row = 5'($urandom);
        pick   = $urandom_range(99);
        if (pick < 62) begin
            sel = $urandom_range(199);
            if (sel == 0) begin
                it.chr = CH_FF;
            end else if (sel < 25) begin
                case ($urandom_range(3))
                    0: it.chr = CH_NL;
                    1: it.chr = CH_CR;
                    2: it.chr = CH_BS;
                    default: it.chr = CH_TAB;
                endcase
            end else if (sel < 31) begin
                it.chr = 8'($urandom_range(31));
            end else begin
                it.chr = 8'($urandom_range(CH_SPACE, 8'hFF));
            end
        end else if (pick < 75) begin
            it.op = OP_SET;
            // Mostly in range, with a lean towards the bottom rows to provoke scrolling.
            if ($urandom_range(4) != 0) begin
                it.col = 7'($urandom_range(COLS - 1));
                it.row = 5'(($urandom_range(2) == 0) ? $urandom_range(LINES - 3, LINES - 1)
                                                     : $urandom_range(LINES - 1));
            end
        end else if (pick < 95) begin
            it.op = OP_READ;
            sel   = $urandom_range(9);
            if (sel < 5) begin
                it.row = 5'(shadow.cur_row);
                it.col = 7'((shadow.cur_col > 0) ? shadow.cur_col - 1 : 0);
            end else if (sel < 8) begin
                it.col = 7'($urandom_range(COLS - 1));
                it.row = 5'($urandom_range(LINES - 1));
            end
        end else begin
            it.op = OP_NONE;
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TW'(it);
        do @(posedge i_clk); while (!o_s_tready);
        shadow.apply_item(it);
    endtask

    // Stops the sender and waits until every owed report has arrived.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (shadow.awaited.size() != 0);
    endtask

    task automatic write_register(input t_cfg_idx idx, input t_cfg_data val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow.set_register(idx, val);
    endtask

    task automatic configure(input t_cfg_data fg, input t_cfg_data bg, input t_cfg_data blink);
        write_register(CFG_FG, fg);
        write_register(CFG_BG, bg);
        write_register(CFG_BLINK, blink);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain_results();
            send_item(random_item());
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(make_item(OP_READ, 8'h00, 0, 0));
        send_item(make_item(OP_PUT, 8'h41, 0, 0));
        send_item(make_item(OP_PUT, 8'hFF, 127, 31));
        send_item(make_item(OP_PUT, 8'h00, 0, 0));
        send_item(make_item(OP_PUT, CH_BS, 0, 0));
        send_item(make_item(OP_PUT, CH_CR, 0, 0));
        send_item(make_item(OP_PUT, CH_BS, 0, 0));
        send_item(make_item(OP_PUT, CH_TAB, 0, 0));
        send_item(make_item(OP_PUT, CH_NL, 0, 0));
        send_item(make_item(OP_SET, 8'hFF, 127, 31));
        // Printing in the last cell leaves a wrap pending; the next put scrolls.
        send_item(make_item(OP_PUT, 8'h5A, 0, 0));
        send_item(make_item(OP_READ, 8'h00, COLS - 1, LINES - 1));
        send_item(make_item(OP_PUT, 8'h79, 0, 0));
        send_item(make_item(OP_READ, 8'h00, COLS - 1, LINES - 2));
        send_item(make_item(OP_PUT, CH_NL, 0, 0));
        send_item(make_item(OP_NONE, 8'hFF, 127, 31));
        send_item(make_item(OP_PUT, 8'h71, 0, 0));
        send_item(make_item(OP_READ, 8'h00, COLS, 0));
        send_item(make_item(OP_READ, 8'h00, 0, LINES));
        send_item(make_item(OP_READ, 8'h00, 127, 31));
        send_item(make_item(OP_SET, 8'h00, COLS - 5, 3));
        send_item(make_item(OP_PUT, CH_TAB, 0, 0));
        send_item(make_item(OP_PUT, CH_TAB, 0, 0));
        send_item(make_item(OP_PUT, CH_FF, 0, 0));
        send_item(make_item(OP_READ, 8'h00, 10, 10));

        drain_results();
        configure(4'hF, 4'hF, 4'h1);
        run_random(RANDOM_PER_PHASE);

        drain_results();
        send_idle_pct = 78;
        recv_idle_pct = 17;
        configure(4'h0, 4'h0, 4'h0);
        run_random(RANDOM_PER_PHASE);

        drain_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)));
        run_random(RANDOM_PER_PHASE);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/tcw_pkg.sv
src/tcw_ram.sv
src/text_console_writer_core.sv
tb/text_console_writer_core_tb.sv
